/* rtl/pcp_pkg.sv */
// shared types and constants for the png chunk parser
`timescale 1ns / 1ps

package pcp_pkg;

   // parse phases
   localparam logic [2:0] PH_SIG  = 3'd0;
   localparam logic [2:0] PH_LEN  = 3'd1;
   localparam logic [2:0] PH_TYPE = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_CRC  = 3'd4;
   localparam logic [2:0] PH_HALT = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CRC_BAD = 2'd1;
   localparam logic [1:0] ST_SIG_BAD = 2'd2;

   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
   localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] chunk_kind_code;
      logic [31:0] chunk_size;
      logic        is_end_chunk;
      logic        is_header_chunk;
      logic [31:0] image_width;
      logic [31:0] image_height;
      logic [7:0]  sample_depth;
      logic [7:0]  colour_kind;
      logic [7:0]  compression_kind;
      logic [7:0]  filter_kind;
      logic [7:0]  interlace_kind;
   } pcp_result_type;

endpackage

/* rtl/pcp_req_if.sv */
// byte input channel
`timescale 1ns / 1ps

interface pcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

/* rtl/pcp_rsp_if.sv */
// chunk report channel
`timescale 1ns / 1ps

interface pcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] chunk_kind_code;
   logic [31:0] chunk_size;
   logic        is_end_chunk;
   logic        is_header_chunk;
   logic [31:0] image_width;
   logic [31:0] image_height;
   logic [7:0]  sample_depth;
   logic [7:0]  colour_kind;
   logic [7:0]  compression_kind;
   logic [7:0]  filter_kind;
   logic [7:0]  interlace_kind;

   modport source (
      output valid, output status, output chunk_kind_code, output chunk_size,
      output is_end_chunk, output is_header_chunk, output image_width,
      output image_height, output sample_depth, output colour_kind,
      output compression_kind, output filter_kind, output interlace_kind,
      input ready
   );
   modport sink (
      input valid, input status, input chunk_kind_code, input chunk_size,
      input is_end_chunk, input is_header_chunk, input image_width,
      input image_height, input sample_depth, input colour_kind,
      input compression_kind, input filter_kind, input interlace_kind,
      output ready
   );
endinterface

/* rtl/png_chunk_parser_crc_check.sv */
// png chunk stream parser top level: input register, parser, report register
// a byte that completes a chunk passes the input register, and its report is then held in the report register
// throughput: one byte per cycle; a byte stalls only when it completes a chunk while
// the previous report is still held on the rsp side
// reset (synchronous, active high) returns to the signature check and clears both stages
`timescale 1ns / 1ps

module png_chunk_parser_crc_check import pcp_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   pcp_req_if.sink   req_chan,
   pcp_rsp_if.source rsp_chan
);

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           out_valid_ff, out_valid_in;
   pcp_result_type out_data_ff;

   logic           emit;
   pcp_result_type result;
   logic           blocked;
   logic           advance;

   // a finished chunk waits only if the report register is still full
   assign blocked       = in_valid_ff && emit && out_valid_ff && !rsp_chan.ready;
   assign advance       = in_valid_ff && !blocked;
   assign req_chan.ready = !in_valid_ff || advance;

   pcp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(advance),
      .data_byte (in_byte_ff),
      .emit      (emit),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.data_byte;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.status           = out_data_ff.status;
   assign rsp_chan.chunk_kind_code  = out_data_ff.chunk_kind_code;
   assign rsp_chan.chunk_size       = out_data_ff.chunk_size;
   assign rsp_chan.is_end_chunk     = out_data_ff.is_end_chunk;
   assign rsp_chan.is_header_chunk  = out_data_ff.is_header_chunk;
   assign rsp_chan.image_width      = out_data_ff.image_width;
   assign rsp_chan.image_height     = out_data_ff.image_height;
   assign rsp_chan.sample_depth     = out_data_ff.sample_depth;
   assign rsp_chan.colour_kind      = out_data_ff.colour_kind;
   assign rsp_chan.compression_kind = out_data_ff.compression_kind;
   assign rsp_chan.filter_kind      = out_data_ff.filter_kind;
   assign rsp_chan.interlace_kind   = out_data_ff.interlace_kind;

endmodule

/* rtl/pcp_crc_byte.sv */
// reflected crc-32 update over one byte
`timescale 1ns / 1ps

module pcp_crc_byte import pcp_pkg::*; (
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [31:0] crc_next
);

   always_comb begin
      logic [31:0] acc;
      acc = crc_cur ^ {24'd0, data_byte};
      for (int k = 0; k < 8; k++) begin
         acc = acc[0] ? (CRC_POLY ^ (acc >> 1)) : (acc >> 1);
      end
      crc_next = acc;
   end

endmodule

/* rtl/pcp_parser.sv */
// chunk framing state, crc accumulation and header capture
`timescale 1ns / 1ps

module pcp_parser import pcp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_valid,
   input  logic [7:0]     data_byte,
   output logic           emit,
   output pcp_result_type result
);

   localparam logic [7:0] SIG_BYTES [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                            8'h0D, 8'h0A, 8'h1A, 8'h0A};

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] type_ff, type_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] rx_crc_ff, rx_crc_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [7:0]  method_ff [5];
   logic [7:0]  method_in [5];
   logic        sig_bad_ff, sig_bad_in;

   logic [31:0] crc_next;
   logic [31:0] count_inc;
   logic        crc_bad;
   logic        is_hdr;
   logic        is_end;

   pcp_crc_byte u_crc (
      .crc_cur   (crc_ff),
      .data_byte (data_byte),
      .crc_next  (crc_next)
   );

   assign count_inc = count_ff + 32'd1;
   assign is_hdr    = (type_ff == TYPE_IHDR);
   assign is_end    = (type_ff == TYPE_IEND);

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      type_in    = type_ff;
      crc_in     = crc_ff;
      rx_crc_in  = rx_crc_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      method_in  = method_ff;
      sig_bad_in = sig_bad_ff;
      crc_bad    = 1'b0;
      emit       = 1'b0;
      result     = '0;

      unique case (phase_ff)
         PH_SIG: begin
            sig_bad_in = sig_bad_ff | (data_byte != SIG_BYTES[count_ff[2:0]]);
            count_in   = count_inc;
            if (count_ff[2:0] == 3'd7) begin
               count_in = '0;
               if (sig_bad_in) begin
                  emit          = 1'b1;
                  result.status = ST_SIG_BAD;
                  phase_in      = PH_HALT;
               end else begin
                  phase_in = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            length_in = {length_ff[23:0], data_byte};
            count_in  = count_inc;
            if (count_ff[1:0] == 2'd3) begin
               count_in  = '0;
               type_in   = '0;
               crc_in    = CRC_INIT;
               width_in  = '0;
               height_in = '0;
               for (int m = 0; m < 5; m++) begin
                  method_in[m] = '0;
               end
               phase_in  = PH_TYPE;
            end
         end
         PH_TYPE: begin
            type_in  = {type_ff[23:0], data_byte};
            crc_in   = crc_next;
            count_in = count_inc;
            if (count_ff[1:0] == 2'd3) begin
               count_in  = '0;
               rx_crc_in = '0;
               phase_in  = (length_ff == 32'd0) ? PH_CRC : PH_DATA;
            end
         end
         PH_DATA: begin
            crc_in = crc_next;
            // header fields come from the first thirteen data bytes only
            if (is_hdr && (count_ff < 32'd13)) begin
               case (count_ff[3:0])
                  4'd0:  width_in[31:24]  = data_byte;
                  4'd1:  width_in[23:16]  = data_byte;
                  4'd2:  width_in[15:8]   = data_byte;
                  4'd3:  width_in[7:0]    = data_byte;
                  4'd4:  height_in[31:24] = data_byte;
                  4'd5:  height_in[23:16] = data_byte;
                  4'd6:  height_in[15:8]  = data_byte;
                  4'd7:  height_in[7:0]   = data_byte;
                  4'd8:  method_in[0]     = data_byte;
                  4'd9:  method_in[1]     = data_byte;
                  4'd10: method_in[2]     = data_byte;
                  4'd11: method_in[3]     = data_byte;
                  4'd12: method_in[4]     = data_byte;
                  default: ;
               endcase
            end
            count_in = count_inc;
            if (count_inc == length_ff) begin
               count_in  = '0;
               rx_crc_in = '0;
               phase_in  = PH_CRC;
            end
         end
         PH_CRC: begin
            rx_crc_in = {rx_crc_ff[23:0], data_byte};
            count_in  = count_inc;
            if (count_ff[1:0] == 2'd3) begin
               count_in = '0;
               crc_bad  = (rx_crc_in != ~crc_ff);
               emit     = 1'b1;
               result.status          = crc_bad ? ST_CRC_BAD : ST_OK;
               result.chunk_kind_code = type_ff;
               result.chunk_size      = length_ff;
               result.is_end_chunk    = is_end;
               result.is_header_chunk = is_hdr;
               if (is_hdr) begin
                  result.image_width      = width_ff;
                  result.image_height     = height_ff;
                  result.sample_depth     = method_ff[0];
                  result.colour_kind      = method_ff[1];
                  result.compression_kind = method_ff[2];
                  result.filter_kind      = method_ff[3];
                  result.interlace_kind   = method_ff[4];
               end
               length_in = '0;
               phase_in  = (crc_bad || is_end) ? PH_HALT : PH_LEN;
            end
         end
         default: ;  // halted: bytes are swallowed
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SIG;
         count_ff   <= '0;
         length_ff  <= '0;
         type_ff    <= '0;
         crc_ff     <= CRC_INIT;
         rx_crc_ff  <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         for (int m = 0; m < 5; m++) begin
            method_ff[m] <= '0;
         end
         sig_bad_ff <= 1'b0;
      end else if (byte_valid) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         length_ff  <= length_in;
         type_ff    <= type_in;
         crc_ff     <= crc_in;
         rx_crc_ff  <= rx_crc_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         method_ff  <= method_in;
         sig_bad_ff <= sig_bad_in;
      end
   end

endmodule

/* sim/testbench.sv */
// self-checking testbench for the png chunk parser: byte stream driver, report monitor
`timescale 1ns / 1ps

module testbench;
   import pcp_pkg::*;

   localparam int unsigned    ITEMS_TARGET    = 1550;
   localparam int unsigned    TAIL_BYTES      = 150;
   localparam int unsigned    HOLD_OFF_CYCLES = 400;
   localparam int unsigned    DRAIN_CYCLES    = 20;
   localparam int unsigned    CYCLE_LIMIT     = 200000;
   localparam int unsigned    MAX_REPORTED    = 10;
   localparam logic [63:0]    PNG_SIGNATURE   = 64'h8950_4E47_0D0A_1A0A;

   typedef logic [7:0] byte_list_type[$];

   logic clock = 1'b0;
   logic reset = 1'b1;

   pcp_req_if req_bus ();
   pcp_rsp_if rsp_bus ();

   png_chunk_parser_crc_check DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   // stimulus and expectations
   logic [7:0]      byte_queue[$];
   pcp_result_type  expected_reports[$];

   int unsigned error_count   = 0;
   int unsigned reports_seen  = 0;
   int unsigned cycle_count   = 0;
   int unsigned send_gap      = 0;
   int unsigned stall_gap     = 0;
   int unsigned hold_cycles   = 0;
   bit          hold_done     = 1'b0;
   bit          byte_taken    = 1'b0;

   // parser state as predicted
   logic [2:0]  parse_phase;
   logic [31:0] byte_pos;
   logic [31:0] chunk_len;
   logic [31:0] chunk_type;
   logic [31:0] crc_acc;
   logic [31:0] crc_rx;
   logic [31:0] hdr_width;
   logic [31:0] hdr_height;
   logic [7:0]  hdr_method[5];
   bit          sig_wrong;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic byte_list_type random_bytes(input int unsigned n);
      byte_list_type q;
      for (int unsigned i = 0; i < n; i++) begin
         q.push_back(8'($urandom_range(0, 255)));
      end
      return q;
   endfunction

   function automatic logic [31:0] random_kind();
      logic [31:0] k;
      do begin
         k = $urandom();
      end while (k == TYPE_IEND);
      return k;
   endfunction

   // length, type, data and crc of one chunk; spoil flips one crc bit
   task automatic add_chunk(input logic [31:0] kind, input byte_list_type body, input bit spoil);
      logic [31:0] c;
      logic [31:0] n;
      c = CRC_INIT;
      n = body.size();
      for (int i = 3; i >= 0; i--) byte_queue.push_back(n[8*i +: 8]);
      for (int i = 3; i >= 0; i--) begin
         byte_queue.push_back(kind[8*i +: 8]);
         c = crc_byte(c, kind[8*i +: 8]);
      end
      foreach (body[i]) begin
         byte_queue.push_back(body[i]);
         c = crc_byte(c, body[i]);
      end
      c = c ^ CRC_INIT;
      if (spoil) c = c ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 3; i >= 0; i--) byte_queue.push_back(c[8*i +: 8]);
   endtask

   task automatic clear_header();
      hdr_width  = '0;
      hdr_height = '0;
      for (int j = 0; j < 5; j++) hdr_method[j] = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b);
      pcp_result_type r;
      bit             bad;
      r = '0;
      case (parse_phase)
         PH_SIG: begin
            if (b != PNG_SIGNATURE[8*(7 - byte_pos[2:0]) +: 8]) sig_wrong = 1'b1;
            byte_pos++;
            if (byte_pos >= 8) begin
               byte_pos = '0;
               if (sig_wrong) begin
                  r.status = ST_SIG_BAD;
                  expected_reports.push_back(r);
                  parse_phase = PH_HALT;
               end else begin
                  parse_phase = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            chunk_len = {chunk_len[23:0], b};
            byte_pos++;
            if (byte_pos >= 4) begin
               byte_pos    = '0;
               chunk_type  = '0;
               crc_acc     = CRC_INIT;
               clear_header();
               parse_phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            chunk_type = {chunk_type[23:0], b};
            crc_acc    = crc_byte(crc_acc, b);
            byte_pos++;
            if (byte_pos >= 4) begin
               byte_pos    = '0;
               crc_rx      = '0;
               parse_phase = (chunk_len == 0) ? PH_CRC : PH_DATA;
            end
         end
         PH_DATA: begin
            crc_acc = crc_byte(crc_acc, b);
            if (chunk_type == TYPE_IHDR && byte_pos < 13) begin
               if (byte_pos < 4)      hdr_width[8*(3 - byte_pos) +: 8]  = b;
               else if (byte_pos < 8) hdr_height[8*(7 - byte_pos) +: 8] = b;
               else                   hdr_method[byte_pos - 8]          = b;
            end
            byte_pos++;
            if (byte_pos == chunk_len) begin
               byte_pos    = '0;
               crc_rx      = '0;
               parse_phase = PH_CRC;
            end
         end
         PH_CRC: begin
            crc_rx = {crc_rx[23:0], b};
            byte_pos++;
            if (byte_pos >= 4) begin
               byte_pos = '0;
               bad = (crc_rx != (crc_acc ^ CRC_INIT));
               r.status          = bad ? ST_CRC_BAD : ST_OK;
               r.chunk_kind_code = chunk_type;
               r.chunk_size      = chunk_len;
               r.is_end_chunk    = (chunk_type == TYPE_IEND);
               r.is_header_chunk = (chunk_type == TYPE_IHDR);
               if (r.is_header_chunk) begin
                  r.image_width      = hdr_width;
                  r.image_height     = hdr_height;
                  r.sample_depth     = hdr_method[0];
                  r.colour_kind      = hdr_method[1];
                  r.compression_kind = hdr_method[2];
                  r.filter_kind      = hdr_method[3];
                  r.interlace_kind   = hdr_method[4];
               end
               expected_reports.push_back(r);
               chunk_len   = '0;
               parse_phase = (bad || r.is_end_chunk) ? PH_HALT : PH_LEN;
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTED)
            $display("report %0d: %s expected %h got %h", reports_seen, name, want, got);
      end
   endtask

   // driver: new byte or idle cycle at each falling edge, unless the current byte is still waiting
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || byte_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (byte_queue.size() > TAIL_BYTES && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 6);
            req_bus.valid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            req_bus.valid     <= 1'b1;
            req_bus.data_byte <= byte_queue.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && reports_seen >= 4) begin
         hold_done   = 1'b1;
         hold_cycles = HOLD_OFF_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_gap > 0) begin
         stall_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (byte_queue.size() > TAIL_BYTES && $urandom_range(0, 7) == 0) begin
         stall_gap = $urandom_range(0, 6);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor: predict on each byte transfer, check each report transfer
   always @(posedge clock) begin
      pcp_result_type got;
      pcp_result_type want;
      if (reset) begin
         byte_taken = 1'b0;
      end else begin
         byte_taken = req_bus.valid && req_bus.ready;
         if (byte_taken) parse_byte(req_bus.data_byte);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status           = rsp_bus.status;
            got.chunk_kind_code  = rsp_bus.chunk_kind_code;
            got.chunk_size       = rsp_bus.chunk_size;
            got.is_end_chunk     = rsp_bus.is_end_chunk;
            got.is_header_chunk  = rsp_bus.is_header_chunk;
            got.image_width      = rsp_bus.image_width;
            got.image_height     = rsp_bus.image_height;
            got.sample_depth     = rsp_bus.sample_depth;
            got.colour_kind      = rsp_bus.colour_kind;
            got.compression_kind = rsp_bus.compression_kind;
            got.filter_kind      = rsp_bus.filter_kind;
            got.interlace_kind   = rsp_bus.interlace_kind;
            if (expected_reports.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTED)
                  $display("report %0d: none expected, got type %h status %0d",
                           reports_seen, got.chunk_kind_code, got.status);
            end else begin
               want = expected_reports.pop_front();
               check_field("status", want.status, got.status);
               check_field("chunk_kind_code", want.chunk_kind_code, got.chunk_kind_code);
               check_field("chunk_size", want.chunk_size, got.chunk_size);
               check_field("is_end_chunk", want.is_end_chunk, got.is_end_chunk);
               check_field("is_header_chunk", want.is_header_chunk, got.is_header_chunk);
               check_field("image_width", want.image_width, got.image_width);
               check_field("image_height", want.image_height, got.image_height);
               check_field("sample_depth", want.sample_depth, got.sample_depth);
               check_field("colour_kind", want.colour_kind, got.colour_kind);
               check_field("compression_kind", want.compression_kind, got.compression_kind);
               check_field("filter_kind", want.filter_kind, got.filter_kind);
               check_field("interlace_kind", want.interlace_kind, got.interlace_kind);
            end
            reports_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      byte_list_type body;
      int unsigned   pick;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      rsp_bus.ready     = 1'b0;

      parse_phase = PH_SIG;
      byte_pos    = '0;
      chunk_len   = '0;
      chunk_type  = '0;
      crc_acc     = CRC_INIT;
      crc_rx      = '0;
      sig_wrong   = 1'b0;
      clear_header();

      // signature, then a full header with extreme field values
      for (int i = 7; i >= 0; i--) byte_queue.push_back(PNG_SIGNATURE[8*i +: 8]);
      body = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
              8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
      add_chunk(TYPE_IHDR, body, 1'b0);

      // well-formed chunks: short, exact and oversized headers, empty chunks, chunks of random type with data
      while (byte_queue.size() < ITEMS_TARGET - 60) begin
         pick = $urandom_range(0, 99);
         if (pick < 20)      add_chunk(TYPE_IHDR, random_bytes($urandom_range(0, 20)), 1'b0);
         else if (pick < 30) add_chunk(random_kind(), random_bytes(0), 1'b0);
         else if (pick < 35) add_chunk(random_kind(), random_bytes($urandom_range(40, 120)), 1'b0);
         else                add_chunk(random_kind(), random_bytes($urandom_range(1, 24)), 1'b0);
      end

      // the last chunk stops the parser: clean end, end with bad crc, or a crc mismatch
      pick = $urandom_range(0, 2);
      if (pick == 0)      add_chunk(TYPE_IEND, random_bytes(0), 1'b0);
      else if (pick == 1) add_chunk(TYPE_IEND, random_bytes($urandom_range(0, 4)), 1'b1);
      else                add_chunk(random_kind(), random_bytes($urandom_range(0, 16)), 1'b1);

      // everything after the stop must be swallowed without a report
      body = random_bytes(20);
      foreach (body[i]) byte_queue.push_back(body[i]);
      add_chunk(TYPE_IHDR, random_bytes(13), 1'b0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_queue.size() > 0 || req_bus.valid || expected_reports.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/pcp_pkg.sv
rtl/pcp_req_if.sv
rtl/pcp_rsp_if.sv
rtl/pcp_crc_byte.sv
rtl/pcp_parser.sv
rtl/png_chunk_parser_crc_check.sv
sim/testbench.sv
